/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i. They are compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk_i, and ignored while rst_ni is low.
`define SR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("segment tree range minimum: assertion failed");

// Checked on every rising edge of clk_i, during reset as well.
`define SR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("segment tree range minimum: assertion failed");

`else

`define SR_ASSERT(lbl, prop)
`define SR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* hdl/strmin_pkg.sv */
// ----------------------------------------------------------------------------
// strmin_pkg
// Shared types, constants and helpers of the segment tree range minimum block.
// ----------------------------------------------------------------------------
`default_nettype none

package strmin_pkg;

  localparam int VAL_W      = 32;
  localparam int POS_W      = 10;
  localparam int LEAVES_DEF = 1024;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;

  // Value held by every node that no loaded leaf has reached yet.
  localparam value_t SENTINEL = 32'sd1000000007;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_QUERY,
    ST_DONE
  } state_e;

  function automatic value_t min_val(input value_t a, input value_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

/* hdl/strmin_node_ram.sv */
// ----------------------------------------------------------------------------
// strmin_node_ram
// Node store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module strmin_node_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

/* hdl/segment_tree_range_min.sv */
// ----------------------------------------------------------------------------
// segment_tree_range_min
// Range minimum over a bottom-up segment tree of signed 32-bit values.
// ----------------------------------------------------------------------------
// The tree lives in a node store of 2*T entries, T being LEAVES rounded up to
// a power of two (1024 by default, so 2048 entries), node 1 the root and leaf
// p at T+p. After reset the block first writes the sentinel 1000000007 into
// every node, one entry a cycle, and holds in_stall_o high until it is done.
// A load item writes the next leaf and walks up to the root, reading one
// sibling and writing one parent per cycle; loads past LEAVES are taken and
// dropped. A query item climbs both range ends together, reading up to two
// nodes a level on the two read ports of the store, then hands its minimum
// to the output register; an empty range or one that starts beyond the tree
// skips the climb. One item is worked on at a time; the next one is taken
// while a result still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module segment_tree_range_min
  import strmin_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        [9:0]  left_i,
  input  wire logic        [9:0]  right_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [31:0] minimum_o,
  output logic                    range_empty_o
);

  localparam int LEAF_W      = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
  localparam int TREE_LEAVES = 1 << LEAF_W;
  localparam int IDX_W       = LEAF_W + 1;
  localparam int CNT_W       = $clog2(LEAVES + 1);
  localparam int CMP_W       = (POS_W > LEAF_W) ? POS_W : LEAF_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0] node_q, node_d;
  value_t           carry_q, carry_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  value_t           best_q, best_d;
  logic             empty_q, empty_d;
  logic             rd_vld_q, rd_vld_d;
  logic             take_lo_q, take_lo_d;
  logic             take_hi_q, take_hi_d;

  logic   out_valid_q, out_valid_d;
  value_t out_min_q, out_min_d;
  logic   out_empty_q, out_empty_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  value_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr_a;
  logic [IDX_W-1:0] mem_raddr_b;
  logic [VAL_W-1:0] mem_rdata_a;
  logic [VAL_W-1:0] mem_rdata_b;
  value_t           rd_a;
  value_t           rd_b;

  logic             in_accept;
  logic             can_emit;
  logic             full;
  logic [IDX_W-1:0] leaf_addr;
  logic [IDX_W-1:0] parent;
  value_t           load_min;
  logic [CMP_W-1:0] lo_ext;
  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] hi_clamp;
  logic [IDX_W:0]   lo_inc;
  logic [IDX_W-1:0] hi_dec;
  value_t           take_a;
  value_t           take_b;

  strmin_node_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (VAL_W)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign rd_a = $signed(mem_rdata_a);
  assign rd_b = $signed(mem_rdata_b);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign full       = (cnt_q == CNT_W'(LEAVES));

  // Leaf p sits at T+p, so its index is a leading one above the position.
  assign leaf_addr = {1'b1, cnt_q[LEAF_W-1:0]};
  assign parent    = {1'b0, node_q[IDX_W-1:1]};
  assign load_min  = min_val(carry_q, rd_a);

  assign lo_ext   = CMP_W'(left_i);
  assign hi_ext   = CMP_W'(right_i);
  assign hi_clamp = (hi_ext > CMP_W'(TREE_LEAVES - 1)) ? CMP_W'(TREE_LEAVES - 1) : hi_ext;

  // The left end steps past an odd node, the right end back past an even one.
  assign lo_inc = {1'b0, lo_q} + (IDX_W + 1)'(lo_q[0]);
  assign hi_dec = hi_q - IDX_W'(!hi_q[0]);

  assign take_a = take_lo_q ? rd_a : SENTINEL;
  assign take_b = take_hi_q ? rd_b : SENTINEL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    carry_q     <= carry_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    best_q      <= best_d;
    empty_q     <= empty_d;
    take_lo_q   <= take_lo_d;
    take_hi_q   <= take_hi_d;
    out_min_q   <= out_min_d;
    out_empty_q <= out_empty_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    node_d      = node_q;
    carry_d     = carry_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    best_d      = best_q;
    empty_d     = empty_q;
    rd_vld_d    = 1'b0;
    take_lo_d   = take_lo_q;
    take_hi_d   = take_hi_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = SENTINEL;
    mem_raddr_a = lo_q;
    mem_raddr_b = hi_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_min_d   = out_min_q;
    out_empty_d = out_empty_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          if (kind_i == KIND_LOAD) begin
            if (!full) begin
              mem_we      = 1'b1;
              mem_waddr   = leaf_addr;
              mem_wdata   = value_i;
              mem_raddr_a = leaf_addr ^ IDX_W'(1);
              node_d      = leaf_addr;
              carry_d     = value_i;
              cnt_d       = cnt_q + CNT_W'(1);
              state_d     = ST_LOAD;
            end
          end else begin
            best_d  = SENTINEL;
            empty_d = 1'b0;
            lo_d    = {1'b1, lo_ext[LEAF_W-1:0]};
            hi_d    = {1'b1, hi_clamp[LEAF_W-1:0]};
            if (lo_ext > hi_ext) begin
              empty_d = 1'b1;
              state_d = ST_DONE;
            end else if (lo_ext > hi_clamp) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_QUERY;
            end
          end
        end
      end

      ST_LOAD: begin
        // Sibling data is back: the parent takes the smaller of the pair.
        mem_we      = 1'b1;
        mem_waddr   = parent;
        mem_wdata   = load_min;
        carry_d     = load_min;
        node_d      = parent;
        mem_raddr_a = parent ^ IDX_W'(1);
        if (parent == IDX_W'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_QUERY: begin
        // Reads of one level merge into the minimum once the registered read data is back.
        if (rd_vld_q) begin
          best_d = min_val(best_q, min_val(take_a, take_b));
        end
        if (lo_q <= hi_q) begin
          rd_vld_d  = 1'b1;
          take_lo_d = lo_q[0];
          take_hi_d = !hi_q[0];
          lo_d      = lo_inc[IDX_W:1];
          hi_d      = {1'b0, hi_dec[IDX_W-1:1]};
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_min_d   = best_q;
          out_empty_d = empty_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign minimum_o     = out_min_q;
  assign range_empty_o = out_empty_q;

  `SR_ASSERT(a_empty_gives_sentinel,
             (out_valid_q && out_empty_q) |-> (out_min_q == SENTINEL))
  `SR_ASSERT(a_count_in_range, cnt_q <= CNT_W'(LEAVES))
  `SR_ASSERT(a_no_write_in_query, (state_q == ST_QUERY) |-> !mem_we)
  `SR_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `SR_ASSERT(a_full_load_dropped,
             (in_accept && kind_i == KIND_LOAD && full) |=>
               ($stable(cnt_q) && state_q == ST_IDLE))

endmodule

`default_nettype wire
